>>> hdl/spi_master_with_fifos_defines.svh
// ----------------------------------------------------------------------------
// spi_master_with_fifos_defines
// Assertion macros used by the queue of the serial-port master RTL.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_WITH_FIFOS_DEFINES_SVH
`define SPI_MASTER_WITH_FIFOS_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on each clock edge outside reset
`define SPIMF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("spimf: assertion failed");

// Check a property on each clock edge, reset included
`define SPIMF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("spimf: assertion failed");

`else

`define SPIMF_ASSERT(label, clk, rstn, prop)
`define SPIMF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> hdl/spimf_pkg.sv
// ----------------------------------------------------------------------------
// spimf_pkg
// Types, codes and constants of the serial-port master with queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spimf_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int WORD_W          = 16;
    localparam int LEVEL_THRESH    = 4;

    // Last valid register byte offset
    localparam logic [5:0] LAST_OFFSET = 6'h24;

    // Item kinds
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    // Bus access sizes
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } size_t;

    // Queue error codes
    typedef enum logic [1:0] {
        FERR_NONE     = 2'd0,
        FERR_RX_EMPTY = 2'd1,
        FERR_TX_FULL  = 2'd2
    } fifo_err_t;

    // Register word indexes
    typedef enum logic [3:0] {
        REG_CTRL0    = 4'd0,
        REG_CTRL1    = 4'd1,
        REG_DATA     = 4'd2,
        REG_STATUS   = 4'd3,
        REG_PRESCALE = 4'd4,
        REG_IMASK    = 4'd5,
        REG_RAW      = 4'd6,
        REG_MASKED   = 4'd7,
        REG_CLEAR    = 4'd8,
        REG_DMA      = 4'd9
    } reg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic fetch;
        logic exec;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

>>> hdl/spimf_fifo.sv
// ----------------------------------------------------------------------------
// spimf_fifo
// Circular word queue in a memory with a registered head read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spi_master_with_fifos_defines.svh"

module spimf_fifo #(
    parameter int DEPTH = spimf_pkg::QUEUE_DEPTH_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [spimf_pkg::WORD_W-1:0] push_data,
    input  logic                        pop,
    input  logic                        rd_en,
    output logic [spimf_pkg::WORD_W-1:0] rd_data,
    output logic [CW-1:0]               count
);
    import spimf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [WORD_W-1:0] rd_data_reg;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the tail entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Read the head entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

    `SPIMF_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(DEPTH))
    `SPIMF_ASSERT(a_no_pop_empty, aclk, aresetn, pop |-> count_reg != '0)
    `SPIMF_ASSERT(a_no_push_full, aclk, aresetn, push |-> count_reg != CW'(DEPTH))

endmodule

>>> hdl/spimf_ctrl.sv
// ----------------------------------------------------------------------------
// spimf_ctrl
// Sequencer: capture an item, fetch queue heads, execute into the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spimf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  spimf_pkg::dp_sts_t    sts,
    output spimf_pkg::ctrl_cmd_t  cmd
);
    import spimf_pkg::*;

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.fetch   = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            ST_EXEC: begin
                cmd.exec = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/spimf_dpath.sv
// ----------------------------------------------------------------------------
// spimf_dpath
// Register file, bit-rate divider, queues and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spimf_dpath #(
    parameter int QUEUE_DEPTH = spimf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  spimf_pkg::ctrl_cmd_t  cmd,
    output spimf_pkg::dp_sts_t    sts,
    input  logic [1:0]            s_action,
    input  logic [5:0]            s_reg_offset,
    input  logic [1:0]            s_access_size,
    input  logic [31:0]           s_write_data,
    input  logic [15:0]           s_slave_return_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_read_data,
    output logic                  m_access_ok,
    output logic [1:0]            m_fifo_error,
    output logic                  m_irq_line,
    output logic                  m_dma_tx_request,
    output logic                  m_dma_rx_request,
    output logic                  m_shift_valid,
    output logic [15:0]           m_shift_out_word,
    output logic [4:0]            m_shift_bits
);
    import spimf_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Captured item
    logic [1:0]  act_reg;
    logic [5:0]  off_reg;
    logic [1:0]  size_reg;
    logic [31:0] wdata_reg;
    logic [15:0] slave_reg;

    // Block registers
    logic [15:0] ctrl0_reg, ctrl0_next;
    logic [3:0]  ctrl1_reg, ctrl1_next;
    logic [7:0]  pre_reg, pre_next;
    logic [7:0]  imask_reg, imask_next;
    logic [3:0]  raw_reg, raw_next;
    logic [1:0]  dmaen_reg, dmaen_next;
    logic [15:0] brc_reg, brc_next;
    logic        dma_present_reg;
    logic [15:0] reload_reg;
    logic [16:0] reload_prod;

    // Queue interface
    logic              tx_push, tx_pop, rx_push, rx_pop;
    logic [WORD_W-1:0] tx_head, rx_head, rx_wdata;
    logic [CW-1:0]     tx_cnt, rx_cnt, tx_post, rx_post;

    // Step working values
    logic        is_acc, is_wr, ok, recomp, sv;
    logic [31:0] wval, rd;
    logic [15:0] sw, brc_cur;
    fifo_err_t   ferr;
    reg_idx_t    idx;

    // Result register
    logic        m_valid_reg;
    logic [31:0] rd_out_reg;
    logic        ok_out_reg, irq_out_reg, dtx_out_reg, drx_out_reg, sv_out_reg;
    logic [1:0]  ferr_out_reg;
    logic [15:0] sw_out_reg;
    logic [4:0]  bits_out_reg;

    spimf_fifo #(.DEPTH(QUEUE_DEPTH)) u_tx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tx_push),
        .push_data (wval[WORD_W-1:0]),
        .pop       (tx_pop),
        .rd_en     (cmd.fetch),
        .rd_data   (tx_head),
        .count     (tx_cnt)
    );

    spimf_fifo #(.DEPTH(QUEUE_DEPTH)) u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rx_push),
        .push_data (rx_wdata),
        .pop       (rx_pop),
        .rd_en     (cmd.fetch),
        .rd_data   (rx_head),
        .count     (rx_cnt)
    );

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= s_action;
            off_reg   <= s_reg_offset;
            size_reg  <= s_access_size;
            wdata_reg <= s_write_data;
            slave_reg <= s_slave_return_data;
        end
    end

    // Divider reload value, registered during the fetch cycle
    assign reload_prod = 17'({1'b0, ctrl0_reg[15:8]} + 9'd1) * 17'(pre_reg);

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            reload_reg <= (reload_prod[15:0] == 16'd0) ? 16'd1 : reload_prod[15:0];
        end
    end

    // Execute one item against the registers and queues
    always_comb begin
        ctrl0_next = ctrl0_reg;
        ctrl1_next = ctrl1_reg;
        pre_next   = pre_reg;
        imask_next = imask_reg;
        raw_next   = raw_reg;
        dmaen_next = dmaen_reg;
        brc_next   = brc_reg;
        tx_push    = 1'b0;
        tx_pop     = 1'b0;
        rx_push    = 1'b0;
        rx_pop     = 1'b0;
        rx_wdata   = slave_reg;
        rd         = '0;
        ok         = 1'b0;
        ferr       = FERR_NONE;
        sv         = 1'b0;
        sw         = '0;
        recomp     = 1'b0;
        brc_cur    = brc_reg;
        idx        = reg_idx_t'(off_reg[5:2]);
        is_wr      = (act_reg == ACT_WRITE);
        is_acc     = (act_reg inside {ACT_READ, ACT_WRITE}) &&
                     (size_reg inside {SZ_BYTE, SZ_HALF, SZ_WORD}) &&
                     (off_reg[1:0] == 2'b00) && (off_reg <= LAST_OFFSET);

        // Replicate narrow writes across the bus
        case (size_reg)
            SZ_BYTE: wval = {4{wdata_reg[7:0]}};
            SZ_HALF: wval = {2{wdata_reg[15:0]}};
            default: wval = wdata_reg;
        endcase

        if (act_reg == ACT_TICK) begin
            // Count the divider down and shift on expiry
            if (ctrl1_reg[1]) begin
                brc_cur  = (brc_reg == 16'd0) ? reload_reg : brc_reg;
                brc_next = brc_cur - 16'd1;
                if (brc_next == 16'd0) begin
                    if (tx_cnt != '0) begin
                        tx_pop   = 1'b1;
                        sv       = 1'b1;
                        sw       = tx_head;
                        rx_wdata = ctrl1_reg[0] ? tx_head : slave_reg;
                        if (rx_cnt == CW'(QUEUE_DEPTH)) begin
                            raw_next[0] = 1'b1;
                        end else begin
                            rx_push = 1'b1;
                        end
                        recomp = 1'b1;
                    end else if (rx_cnt != '0) begin
                        raw_next[1] = 1'b1;
                        recomp      = 1'b1;
                    end
                end
            end
        end else if (is_acc) begin
            ok = 1'b1;
            case (idx)
                REG_CTRL0: begin
                    if (is_wr) begin
                        ctrl0_next = wval[15:0];
                        recomp     = 1'b1;
                    end else begin
                        rd = 32'(ctrl0_reg);
                    end
                end
                REG_CTRL1: begin
                    if (is_wr) begin
                        ctrl1_next = wval[3:0];
                        recomp     = 1'b1;
                    end else begin
                        rd = 32'(ctrl1_reg);
                    end
                end
                REG_DATA: begin
                    if (is_wr) begin
                        if (tx_cnt == CW'(QUEUE_DEPTH)) begin
                            ferr = FERR_TX_FULL;
                        end else begin
                            tx_push = 1'b1;
                        end
                        recomp = 1'b1;
                    end else if (rx_cnt == '0) begin
                        ferr = FERR_RX_EMPTY;
                    end else begin
                        rd     = 32'(rx_head);
                        rx_pop = 1'b1;
                    end
                end
                REG_STATUS: begin
                    if (is_wr) begin
                        ok = 1'b0;
                    end else begin
                        rd = {27'd0, tx_cnt != '0, rx_cnt == CW'(QUEUE_DEPTH),
                              rx_cnt != '0, tx_cnt != CW'(QUEUE_DEPTH), tx_cnt == '0};
                    end
                end
                REG_PRESCALE: begin
                    if (is_wr) begin
                        pre_next = wval[7:0];
                    end else begin
                        rd = 32'(pre_reg);
                    end
                end
                REG_IMASK: begin
                    if (is_wr) begin
                        imask_next = wval[7:0];
                        recomp     = 1'b1;
                    end else begin
                        rd = 32'(imask_reg);
                    end
                end
                REG_RAW: begin
                    if (is_wr) begin
                        ok = 1'b0;
                    end else begin
                        rd = 32'(raw_reg);
                    end
                end
                REG_MASKED: begin
                    if (is_wr) begin
                        ok = 1'b0;
                    end else begin
                        rd = 32'(raw_reg & imask_reg[3:0]);
                    end
                end
                REG_CLEAR: begin
                    if (is_wr) begin
                        raw_next[1:0] = raw_reg[1:0] & ~wval[1:0];
                        recomp        = 1'b1;
                    end
                end
                REG_DMA: begin
                    if (is_wr) begin
                        dmaen_next = wval[1:0];
                        recomp     = 1'b1;
                    end else begin
                        rd = 32'(dmaen_reg);
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase

            // Truncate reads to the access size
            if (is_wr || !ok) begin
                rd = '0;
            end else if (size_reg == SZ_BYTE) begin
                rd = {24'd0, rd[7:0]};
            end else if (size_reg == SZ_HALF) begin
                rd = {16'd0, rd[15:0]};
            end
        end

        // Queue levels after this item
        tx_post = tx_cnt + CW'(tx_push) - CW'(tx_pop);
        rx_post = rx_cnt + CW'(rx_push) - CW'(rx_pop);

        // Recompute the level bits
        if (recomp) begin
            raw_next[3] = (tx_post < CW'(LEVEL_THRESH));
            raw_next[2] = (rx_post >= CW'(LEVEL_THRESH));
        end

        // Queue updates take effect only when the item executes
        tx_push = tx_push & cmd.exec;
        tx_pop  = tx_pop & cmd.exec;
        rx_push = rx_push & cmd.exec;
        rx_pop  = rx_pop & cmd.exec;
    end

    // Update block registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl0_reg       <= '0;
            ctrl1_reg       <= '0;
            pre_reg         <= '0;
            imask_reg       <= '0;
            raw_reg         <= '0;
            dmaen_reg       <= '0;
            brc_reg         <= '0;
            dma_present_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                ctrl0_reg <= ctrl0_next;
                ctrl1_reg <= ctrl1_next;
                pre_reg   <= pre_next;
                imask_reg <= imask_next;
                raw_reg   <= raw_next;
                dmaen_reg <= dmaen_next;
                brc_reg   <= brc_next;
            end
            if (cfg_wr_en) begin
                dma_present_reg <= cfg_wr_data;
            end
        end
    end

    // Result valid: set on execute, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rd_out_reg   <= rd;
            ok_out_reg   <= ok;
            ferr_out_reg <= ferr;
            irq_out_reg  <= ((raw_next & imask_next[3:0]) != 4'd0);
            dtx_out_reg  <= dma_present_reg && dmaen_next[1] &&
                            (tx_post < CW'(LEVEL_THRESH));
            drx_out_reg  <= dma_present_reg && dmaen_next[0] &&
                            (rx_post >= CW'(LEVEL_THRESH));
            sv_out_reg   <= sv;
            sw_out_reg   <= sw;
            bits_out_reg <= {1'b0, ctrl0_next[3:0]} + 5'd1;
        end
    end

    assign sts.out_free     = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_read_data      = rd_out_reg;
    assign m_access_ok      = ok_out_reg;
    assign m_fifo_error     = ferr_out_reg;
    assign m_irq_line       = irq_out_reg;
    assign m_dma_tx_request = dtx_out_reg;
    assign m_dma_rx_request = drx_out_reg;
    assign m_shift_valid    = sv_out_reg;
    assign m_shift_out_word = sw_out_reg;
    assign m_shift_bits     = bits_out_reg;

endmodule

>>> hdl/spi_master_with_fifos.sv
// ----------------------------------------------------------------------------
// spi_master_with_fifos
// Serial-port master with transmit and receive word queues, bus registers,
// bit-rate divider, level interrupt and DMA request outputs.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    action, reg_offset, access_size,
//                                   write_data, slave_return_data
// m_        out  m_valid/m_ready    read_data, access_ok, fifo_error, irq_line,
//                                   dma requests, shift_valid/word/bits
// cfg_      in   cfg_wr_en          cfg_wr_data (DMA lines present)
//
// An item goes through capture, fetch of both queue heads from the
// registered read port of their memories, then execute into the result
// register. The next item is taken in the cycle after execute, so no new
// item is taken before the last one has executed.
// A result waiting on m_ready does not block the capture of the next item;
// that item waits in execute until the result register is free.
// aresetn is synchronous, active low, clears control state, block registers, queue
// pointers and result valid; queue memory and data registers stay as is.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_master_with_fifos #(
    parameter int QUEUE_DEPTH = spimf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [5:0]  s_reg_offset,
    input  logic [1:0]  s_access_size,
    input  logic [31:0] s_write_data,
    input  logic [15:0] s_slave_return_data,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_access_ok,
    output logic [1:0]  m_fifo_error,
    output logic        m_irq_line,
    output logic        m_dma_tx_request,
    output logic        m_dma_rx_request,
    output logic        m_shift_valid,
    output logic [15:0] m_shift_out_word,
    output logic [4:0]  m_shift_bits
);
    import spimf_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    spimf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    spimf_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_action            (s_action),
        .s_reg_offset        (s_reg_offset),
        .s_access_size       (s_access_size),
        .s_write_data        (s_write_data),
        .s_slave_return_data (s_slave_return_data),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_read_data         (m_read_data),
        .m_access_ok         (m_access_ok),
        .m_fifo_error        (m_fifo_error),
        .m_irq_line          (m_irq_line),
        .m_dma_tx_request    (m_dma_tx_request),
        .m_dma_rx_request    (m_dma_rx_request),
        .m_shift_valid       (m_shift_valid),
        .m_shift_out_word    (m_shift_out_word),
        .m_shift_bits        (m_shift_bits)
    );

endmodule

>>> tb/spi_master_with_fifos_test.sv
// ----------------------------------------------------------------------------
// spi_master_with_fifos_test
// Self-checking bench for the serial-port master. A directed table covers
// reset values, rejected accesses, register extremes and one shift. Four
// random phases follow, alternating the DMA lines and the read pressure. The
// sender and the receiver both stall at random. Each result is checked field
// by field against a cycle-free predictor of the registers and queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_master_with_fifos_test;
    import spimf_pkg::*;

    localparam int DEPTH         = QUEUE_DEPTH_DEF;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;

    // Codes outside the enums, used to provoke rejects
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [1:0] SZ_BAD   = 2'd3;

    // Raw interrupt status bits
    localparam logic [3:0] IRQ_OVERRUN  = 4'h1;
    localparam logic [3:0] IRQ_TIMEOUT  = 4'h2;
    localparam logic [3:0] IRQ_RX_LEVEL = 4'h4;
    localparam logic [3:0] IRQ_TX_LEVEL = 4'h8;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  offset;
        logic [1:0]  size;
        logic [31:0] wdata;
        logic [15:0] slave;
    } bus_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
        logic [1:0]  fifo_error;
        logic        irq_line;
        logic        dma_tx;
        logic        dma_rx;
        logic        shift_valid;
        logic [15:0] shift_word;
        logic [4:0]  shift_bits;
    } spi_response_t;

    typedef struct {
        bus_item_t   item;
        bit          typed;
        logic [31:0] read_data;
        logic        access_ok;
        fifo_err_t   fifo_error;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = 2'd0;
    logic [5:0]  s_reg_offset = 6'd0;
    logic [1:0]  s_access_size = 2'd0;
    logic [31:0] s_write_data = 32'd0;
    logic [15:0] s_slave_return_data = 16'd0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic        m_access_ok;
    logic [1:0]  m_fifo_error;
    logic        m_irq_line;
    logic        m_dma_tx_request;
    logic        m_dma_rx_request;
    logic        m_shift_valid;
    logic [15:0] m_shift_out_word;
    logic [4:0]  m_shift_bits;

    // Predictor state
    bit [15:0] tx_words[$];
    bit [15:0] rx_words[$];
    bit [15:0] ctl_zero;
    bit [3:0]  ctl_one;
    bit [7:0]  clk_prescale;
    bit [7:0]  int_mask;
    bit [3:0]  int_raw;
    bit [1:0]  dma_en;
    bit [15:0] div_count;
    bit        dma_lines;

    spi_response_t expected_responses[$];
    directed_row_t directed_rows[$];
    int errors = 0;
    int quiet_cycles = 0;
    int send_run = 0;
    int sink_run = 0;

    always #10 aclk = ~aclk;

    spi_master_with_fifos u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_reg_offset        (s_reg_offset),
        .s_access_size       (s_access_size),
        .s_write_data        (s_write_data),
        .s_slave_return_data (s_slave_return_data),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_read_data         (m_read_data),
        .m_access_ok         (m_access_ok),
        .m_fifo_error        (m_fifo_error),
        .m_irq_line          (m_irq_line),
        .m_dma_tx_request    (m_dma_tx_request),
        .m_dma_rx_request    (m_dma_rx_request),
        .m_shift_valid       (m_shift_valid),
        .m_shift_out_word    (m_shift_out_word),
        .m_shift_bits        (m_shift_bits)
    );

    function automatic logic [5:0] reg_addr(reg_idx_t r);
        return {r, 2'b00};
    endfunction

    // Rebuild the level bits from the queue fill
    function void refresh_levels();
        int_raw &= ~(IRQ_RX_LEVEL | IRQ_TX_LEVEL);
        if (tx_words.size() < LEVEL_THRESH) int_raw |= IRQ_TX_LEVEL;
        if (rx_words.size() >= LEVEL_THRESH) int_raw |= IRQ_RX_LEVEL;
    endfunction

    // Advance the register and queue state by one item and form its result
    function automatic spi_response_t predict_response(bus_item_t it);
        spi_response_t r;
        logic [31:0]   wval;
        logic [16:0]   reload;
        logic [15:0]   word;
        bit            writing;
        r = '0;
        writing = (it.action == ACT_WRITE);
        if (it.action == ACT_TICK) begin
            if (ctl_one[1]) begin
                // Reload an expired divider, never with zero
                if (div_count == 0) begin
                    reload = (17'(ctl_zero[15:8]) + 17'd1) * 17'(clk_prescale);
                    div_count = (reload == 0) ? 16'd1 : reload[15:0];
                end
                div_count = div_count - 16'd1;
                if (div_count == 0) begin
                    if (tx_words.size() != 0) begin
                        word = tx_words.pop_front();
                        r.shift_valid = 1'b1;
                        r.shift_word = word;
                        if (rx_words.size() >= DEPTH) int_raw |= IRQ_OVERRUN;
                        else rx_words.push_back(ctl_one[0] ? word : it.slave);
                        refresh_levels();
                    end else if (rx_words.size() != 0) begin
                        int_raw |= IRQ_TIMEOUT;
                        refresh_levels();
                    end
                end
            end
        end else if ((it.action == ACT_READ || writing) && it.size != SZ_BAD &&
                     it.offset[1:0] == 2'b00 && it.offset <= LAST_OFFSET) begin
            r.access_ok = 1'b1;
            // Replicate narrow writes across the bus
            case (it.size)
                SZ_BYTE: wval = {4{it.wdata[7:0]}};
                SZ_HALF: wval = {2{it.wdata[15:0]}};
                default: wval = it.wdata;
            endcase
            case (reg_idx_t'(it.offset[5:2]))
                REG_CTRL0: begin
                    if (writing) begin
                        ctl_zero = wval[15:0];
                        refresh_levels();
                    end else r.read_data = 32'(ctl_zero);
                end
                REG_CTRL1: begin
                    if (writing) begin
                        ctl_one = wval[3:0];
                        refresh_levels();
                    end else r.read_data = 32'(ctl_one);
                end
                REG_DATA: begin
                    if (writing) begin
                        if (tx_words.size() >= DEPTH) r.fifo_error = FERR_TX_FULL;
                        else tx_words.push_back(wval[15:0]);
                        refresh_levels();
                    end else if (rx_words.size() == 0) begin
                        r.fifo_error = FERR_RX_EMPTY;
                    end else begin
                        r.read_data = 32'(rx_words.pop_front());
                    end
                end
                REG_STATUS: begin
                    // tx busy, rx full, rx not empty, tx not full, tx empty
                    if (writing) r.access_ok = 1'b0;
                    else r.read_data = {27'd0, tx_words.size() != 0,
                                        rx_words.size() == DEPTH, rx_words.size() != 0,
                                        tx_words.size() != DEPTH, tx_words.size() == 0};
                end
                REG_PRESCALE: begin
                    if (writing) clk_prescale = wval[7:0];
                    else r.read_data = 32'(clk_prescale);
                end
                REG_IMASK: begin
                    if (writing) begin
                        int_mask = wval[7:0];
                        refresh_levels();
                    end else r.read_data = 32'(int_mask);
                end
                REG_RAW: begin
                    if (writing) r.access_ok = 1'b0;
                    else r.read_data = 32'(int_raw);
                end
                REG_MASKED: begin
                    if (writing) r.access_ok = 1'b0;
                    else r.read_data = 32'(int_raw & int_mask[3:0]);
                end
                REG_CLEAR: begin
                    // Clear only the sticky bits; reads return zero
                    if (writing) begin
                        int_raw &= ~(wval[3:0] & (IRQ_OVERRUN | IRQ_TIMEOUT));
                        refresh_levels();
                    end
                end
                default: begin
                    if (writing) begin
                        dma_en = wval[1:0];
                        refresh_levels();
                    end else r.read_data = 32'(dma_en);
                end
            endcase
            if (writing || !r.access_ok) r.read_data = 32'd0;
            else if (it.size == SZ_BYTE) r.read_data &= 32'h0000_00ff;
            else if (it.size == SZ_HALF) r.read_data &= 32'h0000_ffff;
        end
        r.irq_line = |(int_raw & int_mask[3:0]);
        r.dma_tx = dma_lines && dma_en[1] && (tx_words.size() < LEVEL_THRESH);
        r.dma_rx = dma_lines && dma_en[0] && (rx_words.size() >= LEVEL_THRESH);
        r.shift_bits = 5'd1 + 5'(ctl_zero[3:0]);
        return r;
    endfunction

    // Draw a stall length; now and then start a run with no stalls at all
    function automatic int draw_gap(inout int zero_run);
        if (zero_run > 0) begin
            zero_run--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            zero_run = $urandom_range(4, 20);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function void add_row(logic [1:0] act, logic [5:0] off, logic [1:0] sz,
                          logic [31:0] wd, logic [15:0] sl, bit typed,
                          logic [31:0] rd, logic ok, fifo_err_t fe);
        directed_row_t row;
        row.item = '{act, off, sz, wd, sl};
        row.typed = typed;
        row.read_data = rd;
        row.access_ok = ok;
        row.fifo_error = fe;
        directed_rows.push_back(row);
    endfunction

    // Build one random item; noise items come back with shaped low
    function automatic bus_item_t random_item(int read_weight, output bit shaped);
        bus_item_t it;
        reg_idx_t  target;
        int        pick;
        it.action = ACT_READ;
        it.offset = 6'($urandom_range(0, 63));
        it.size = 2'($urandom_range(0, 2));
        it.wdata = $urandom();
        it.slave = 16'($urandom());
        shaped = 1'b1;
        pick = $urandom_range(0, 79 + read_weight);
        if (pick < 35) begin
            it.action = ACT_TICK;
            it.size = 2'($urandom_range(0, 3));
        end else if (pick < 55) begin
            it.action = ACT_WRITE;
            it.offset = reg_addr(REG_DATA);
        end else if (pick < 63) begin
            it.offset = reg_addr(reg_idx_t'($urandom_range(0, 9)));
        end else if (pick < 73) begin
            case ($urandom_range(0, 5))
                0: target = REG_CTRL0;
                1: target = REG_CTRL1;
                2: target = REG_PRESCALE;
                3: target = REG_IMASK;
                4: target = REG_CLEAR;
                default: target = REG_DMA;
            endcase
            it.action = ACT_WRITE;
            it.offset = reg_addr(target);
            // Keep rate and prescale below four so the divider expires often
            if (target == REG_CTRL0) begin
                it.wdata[15:8] = 8'($urandom_range(0, 3));
                if (it.size == SZ_BYTE) it.wdata[7:0] = 8'($urandom_range(0, 3));
            end else if (target == REG_PRESCALE) begin
                it.wdata[7:0] = 8'($urandom_range(0, 3));
            end else if (target == REG_CTRL1) begin
                it.wdata[1] = ($urandom_range(0, 4) != 0);
            end
        end else if (pick < 80) begin
            it.action = 2'($urandom_range(0, 3));
            it.size = 2'($urandom_range(0, 3));
            shaped = 1'b0;
            // Turn stray writes of rate or prescale into reads
            if (it.action == ACT_WRITE && it.size != SZ_BAD && it.offset[1:0] == 2'b00 &&
                (it.offset[5:2] == REG_CTRL0 || it.offset[5:2] == REG_PRESCALE))
                it.action = ACT_READ;
        end else begin
            it.offset = reg_addr(REG_DATA);
        end
        return it;
    endfunction

    // Present one item, hold it until taken, then predict its result
    task automatic send_item(bus_item_t it, output spi_response_t predicted);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= it.action;
        s_reg_offset <= it.offset;
        s_access_size <= it.size;
        s_write_data <= it.wdata;
        s_slave_return_data <= it.slave;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_response(it);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_dma_lines(bit present);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= present;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dma_lines = present;
    endtask

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Check each result against the oldest expectation; count quiet cycles
    always @(posedge aclk) begin
        spi_response_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (m_valid && m_ready) begin
                if (expected_responses.size() == 0) begin
                    errors++;
                    $display("%0t: result expected none, got read_data %h", $time,
                             m_read_data);
                end else begin
                    want = expected_responses.pop_front();
                    check_field("read_data", want.read_data, m_read_data);
                    check_field("access_ok", 32'(want.access_ok), 32'(m_access_ok));
                    check_field("fifo_error", 32'(want.fifo_error), 32'(m_fifo_error));
                    check_field("irq_line", 32'(want.irq_line), 32'(m_irq_line));
                    check_field("dma_tx_request", 32'(want.dma_tx), 32'(m_dma_tx_request));
                    check_field("dma_rx_request", 32'(want.dma_rx), 32'(m_dma_rx_request));
                    check_field("shift_valid", 32'(want.shift_valid), 32'(m_shift_valid));
                    check_field("shift_out_word", 32'(want.shift_word),
                                32'(m_shift_out_word));
                    check_field("shift_bits", 32'(want.shift_bits), 32'(m_shift_bits));
                end
            end
        end
    end

    // Result side: stall a random number of cycles before each result
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = draw_gap(sink_run);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // End the run when nothing has moved for too long
    initial begin : watchdog
        do @(negedge aclk); while (quiet_cycles < QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        spi_response_t predicted;
        bus_item_t     it;
        bit            shaped;
        int            made;

        // Reset values, rejected accesses and register extremes
        add_row(ACT_READ, reg_addr(REG_CTRL0), SZ_WORD, 32'h0, 16'h0,
                1'b1, 32'h0, 1'b1, FERR_NONE);
        add_row(ACT_READ, reg_addr(REG_STATUS), SZ_WORD, 32'h0, 16'h0,
                1'b1, 32'h3, 1'b1, FERR_NONE);
        add_row(ACT_READ, reg_addr(REG_DATA), SZ_WORD, 32'h0, 16'h0,
                1'b1, 32'h0, 1'b1, FERR_RX_EMPTY);
        add_row(ACT_WRITE, reg_addr(REG_STATUS), SZ_WORD, 32'hffff_ffff, 16'h0,
                1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_RAW), SZ_WORD, 32'hffff_ffff, 16'h0,
                1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_MASKED), SZ_HALF, 32'hffff_ffff, 16'h0,
                1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_READ, 6'h02, SZ_WORD, 32'h0, 16'h0, 1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_READ, 6'h28, SZ_WORD, 32'h0, 16'h0, 1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, 6'h3f, SZ_BYTE, 32'hffff_ffff, 16'hffff,
                1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_READ, reg_addr(REG_CTRL0), SZ_BAD, 32'h0, 16'h0,
                1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_NONE, reg_addr(REG_DATA), SZ_WORD, 32'hffff_ffff, 16'hffff,
                1'b1, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_TICK, 6'h0, SZ_WORD, 32'h0, 16'h0, 1'b1, 32'h0, 1'b0, FERR_NONE);
        // Largest prescale and rate, then back to a short divider before enabling
        add_row(ACT_WRITE, reg_addr(REG_PRESCALE), SZ_WORD, 32'hffff_ffff, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_READ, reg_addr(REG_PRESCALE), SZ_WORD, 32'h0, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_CTRL0), SZ_HALF, 32'h0000_ffff, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_READ, reg_addr(REG_CTRL0), SZ_BYTE, 32'h0, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_CTRL0), SZ_WORD, 32'h0000_0007, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_PRESCALE), SZ_BYTE, 32'h0000_0001, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_IMASK), SZ_WORD, 32'hffff_ffff, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_DMA), SZ_WORD, 32'h0000_0003, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_DATA), SZ_WORD, 32'h1234_5678, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        // Enable with loopback, shift one word, clear and read it back
        add_row(ACT_WRITE, reg_addr(REG_CTRL1), SZ_WORD, 32'h0000_0003, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_TICK, 6'h0, SZ_WORD, 32'h0, 16'hffff, 1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_READ, reg_addr(REG_RAW), SZ_WORD, 32'h0, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_WRITE, reg_addr(REG_CLEAR), SZ_WORD, 32'hffff_ffff, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);
        add_row(ACT_READ, reg_addr(REG_DATA), SZ_WORD, 32'h0, 16'h0,
                1'b0, 32'h0, 1'b0, FERR_NONE);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_dma_lines(1'b0);

        // Walk the table; typed rows override the predicted status fields
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, predicted);
            if (directed_rows[i].typed) begin
                predicted.read_data = directed_rows[i].read_data;
                predicted.access_ok = directed_rows[i].access_ok;
                predicted.fifo_error = directed_rows[i].fifo_error;
            end
            expected_responses.push_back(predicted);
        end

        // Random phases alternate the DMA lines and the read pressure
        for (int phase = 1; phase <= 4; phase++) begin
            set_dma_lines(phase[0]);
            made = 0;
            while (made < PHASE_ITEMS) begin
                it = random_item(phase[0] ? 5 : 25, shaped);
                send_item(it, predicted);
                expected_responses.push_back(predicted);
                if (shaped) made++;
            end
        end

        settle();
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spimf_pkg.sv
hdl/spimf_fifo.sv
hdl/spimf_ctrl.sv
hdl/spimf_dpath.sv
hdl/spi_master_with_fifos.sv
tb/spi_master_with_fifos_test.sv
